// File: rtl/frnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frnd_pkg
// types, codes and constants of the ring network derivative unit
// ----------------------------------------------------------------------------
package frnd_pkg;

  // item kinds on tuser of the input stream
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // configuration register indexes
  localparam logic [1:0] RegNeuronCount   = 2'd0;
  localparam logic [1:0] RegNeighbourReach = 2'd1;
  localparam logic [1:0] RegCouplingGain  = 2'd2;
  localparam logic [1:0] RegDriveCurrent  = 2'd3;

  // register reset values
  localparam logic [8:0]         NeuronCountRst = 9'd9;
  localparam logic [6:0]         ReachRst       = 7'd1;
  localparam logic [16:0]        GainRst        = 17'd0;
  localparam logic signed [31:0] DriveRst       = -32'sd22282;

  // 0.75 in q16.16 times 5, recovery offset in raw units
  localparam logic signed [36:0] RecovOffset = 37'sd245760;
  // unsigned 32-bit divide by 15: multiply, then shift right by 35
  localparam logic [31:0] RecipFifteen = 32'h8888_8889;
  // (2^32 - 1) / 15 times sixteen
  localparam logic [33:0] FoldSixteen = 34'h1_1111_1110;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OWN,
    ST_LD_OWN,
    ST_NB,
    ST_SQ,
    ST_CH,
    ST_CL,
    ST_GL,
    ST_GH,
    ST_RM,
    ST_RS,
    ST_A1,
    ST_A2,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } clip_t;

  function automatic clip_t clip32(input logic signed [63:0] v);
    clip_t r;
    if (v > 64'sd2147483647) begin
      r.value = 32'h7FFF_FFFF;
      r.sat   = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.value = 32'h8000_0000;
      r.sat   = 1'b1;
    end else begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/frnd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frnd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module frnd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/frnd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frnd_mul
// shared 32 x 32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module frnd_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/fhn_ring_network_derivative.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhn_ring_network_derivative
// derivative unit for a ring of fitzhugh-nagumo neurons
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores activation and recovery of one neuron. A
// query item (tuser 1) returns the two time derivatives of that neuron,
// q16.16, saturated, after m neighbour reads from its transfer, where m is
// the number of neighbour reads: 2 * neighbour_reach when the reach covers
// less than the ring, the ring size when it covers all of it, and 0 for
// neuron zero or an index outside the ring. The neighbour walk is bound by
// the single read port of the activation ram, the rest by six passes through
// one shared 32 x 32 multiplier (cube, coupling gain, divide by fifteen).
// The input is not ready while a query is in work; a finished result waits in
// the output register, and the next item is taken meanwhile. Entries must be
// written before they are queried or used as a neighbour.
module fhn_ring_network_derivative #(
  parameter int MAX_NEURONS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // neuron_index, activation, recovery
  input  logic [71:0] s_axis_tdata,
  // operation
  input  logic [0:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_index, activation_rate, recovery_rate
  output logic [71:0] m_axis_tdata,
  // saturated
  output logic [0:0]  m_axis_tuser
);

  localparam int AW = $clog2(MAX_NEURONS);
  localparam int RingMax = (MAX_NEURONS < 256) ? MAX_NEURONS : 256;
  localparam logic [8:0] RingMaxW = 9'(RingMax);

  // configuration
  logic [8:0]         count_q;
  logic [6:0]         reach_q;
  logic [16:0]        gain_q;
  logic signed [31:0] drive_q;

  // control
  frnd_pkg::state_e state_q, state_d;
  logic [8:0] cnt_q, cnt_d;
  logic [7:0] up_q, up_d, dn_q, dn_d;
  logic       tog_q, tog_d, full_q, full_d, ring_q, ring_d;
  logic       rd_nb_q, rd_nb_d;
  logic       out_valid_q, out_load;

  // payload
  logic [7:0]         idx_q;
  logic signed [31:0] x_q, w_q;
  logic [31:0]        xmag_q;
  logic               xneg_q;
  logic signed [40:0] acc_q;
  logic [40:0]        sabs_q;
  logic               sneg_q;
  logic [31:0]        sqlo_q;
  logic [61:0]        cube_q;
  logic signed [36:0] num_q;
  logic [35:0]        u_q;
  logic               rneg_q;
  logic [32:0]        z_q;
  logic [31:0]        z2_q;
  logic [33:0]        qb_q, rq_q;
  logic [48:0]        plo_q;
  logic [57:0]        pmag_q;
  logic signed [42:0] c_q;
  logic signed [44:0] s_q;
  logic signed [62:0] cube_s_q;
  logic signed [34:0] rr_q;
  logic signed [63:0] a_q;
  logic [71:0]        out_data_q;
  logic               out_sat_q;

  // datapath wires
  logic [8:0]         ring_n;
  logic               in_acc, in_store;
  logic [7:0]         in_idx;
  logic [7:0]         nb_addr, up_nx, dn_nx;
  logic [AW-1:0]      x_raddr;
  logic [31:0]        x_rdata, w_rdata;
  logic signed [31:0] x_rdata_s, x_own;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [4:0]         fold_hi;
  logic signed [58:0] cpl_s;
  frnd_pkg::clip_t    clip_a, clip_r;

  assign in_idx   = s_axis_tdata[7:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_store = {24'd0, idx_q} < 32'(MAX_NEURONS);
  assign s_axis_tready = (state_q == frnd_pkg::ST_IDLE);

  always_comb begin
    ring_n = (count_q > RingMaxW) ? RingMaxW : count_q;
    if (ring_n == 9'd0) begin
      ring_n = 9'd1;
    end
  end

  // state ram
  frnd_ram #(
    .WIDTH(32),
    .DEPTH(MAX_NEURONS)
  ) u_x_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && s_axis_tuser[0] == frnd_pkg::OpWrite &&
             {24'd0, in_idx} < 32'(MAX_NEURONS)),
    .waddr_i(AW'(in_idx)),
    .wdata_i(s_axis_tdata[39:8]),
    .raddr_i(x_raddr),
    .rdata_o(x_rdata)
  );

  frnd_ram #(
    .WIDTH(32),
    .DEPTH(MAX_NEURONS)
  ) u_w_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && s_axis_tuser[0] == frnd_pkg::OpWrite &&
             {24'd0, in_idx} < 32'(MAX_NEURONS)),
    .waddr_i(AW'(in_idx)),
    .wdata_i(s_axis_tdata[71:40]),
    .raddr_i(AW'(idx_q)),
    .rdata_o(w_rdata)
  );

  frnd_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign x_rdata_s = x_rdata;
  assign x_own     = in_store ? x_rdata_s : 32'sd0;

  // ring neighbour pointers
  assign nb_addr = (full_q || !tog_q) ? up_q : dn_q;
  assign up_nx   = ({1'b0, up_q} + 9'd1 == ring_n) ? 8'd0 : up_q + 8'd1;
  assign dn_nx   = (dn_q == 8'd0) ? 8'(ring_n - 9'd1) : dn_q - 8'd1;

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    up_d     = up_q;
    dn_d     = dn_q;
    tog_d    = tog_q;
    full_d   = full_q;
    ring_d   = ring_q;
    rd_nb_d  = 1'b0;
    out_load = 1'b0;
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    x_raddr  = AW'(idx_q);
    case (state_q)
      frnd_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tuser[0] == frnd_pkg::OpQuery) begin
          state_d = frnd_pkg::ST_RD_OWN;
        end
      end
      frnd_pkg::ST_RD_OWN: begin
        state_d = frnd_pkg::ST_LD_OWN;
      end
      frnd_pkg::ST_LD_OWN: begin
        ring_d = (idx_q != 8'd0) && ({1'b0, idx_q} < ring_n) && (reach_q != 7'd0);
        full_d = ({1'b0, reach_q, 1'b1} >= ring_n);
        cnt_d  = full_d ? ring_n : {1'b0, reach_q, 1'b0};
        up_d   = full_d ? 8'd0 :
                 (({1'b0, idx_q} + 9'd1 == ring_n) ? 8'd0 : idx_q + 8'd1);
        dn_d   = idx_q - 8'd1;
        tog_d  = 1'b0;
        state_d = ring_d ? frnd_pkg::ST_NB : frnd_pkg::ST_SQ;
      end
      frnd_pkg::ST_NB: begin
        x_raddr = AW'(nb_addr);
        rd_nb_d = 1'b1;
        if (full_q || !tog_q) begin
          up_d = up_nx;
        end else begin
          dn_d = dn_nx;
        end
        tog_d = !full_q && !tog_q;
        cnt_d = cnt_q - 9'd1;
        if (cnt_q == 9'd1) begin
          state_d = frnd_pkg::ST_SQ;
        end
      end
      frnd_pkg::ST_SQ: begin
        mul_a   = xmag_q;
        mul_b   = xmag_q;
        state_d = frnd_pkg::ST_CH;
      end
      frnd_pkg::ST_CH: begin
        mul_a   = mul_p[63:32];
        mul_b   = xmag_q;
        state_d = frnd_pkg::ST_CL;
      end
      frnd_pkg::ST_CL: begin
        mul_a   = sqlo_q;
        mul_b   = xmag_q;
        state_d = frnd_pkg::ST_GL;
      end
      frnd_pkg::ST_GL: begin
        mul_a   = {15'd0, gain_q};
        mul_b   = sabs_q[31:0];
        state_d = frnd_pkg::ST_GH;
      end
      frnd_pkg::ST_GH: begin
        mul_a   = {15'd0, gain_q};
        mul_b   = {23'd0, sabs_q[40:32]};
        state_d = frnd_pkg::ST_RM;
      end
      frnd_pkg::ST_RM: begin
        mul_a   = z2_q;
        mul_b   = frnd_pkg::RecipFifteen;
        state_d = frnd_pkg::ST_RS;
      end
      frnd_pkg::ST_RS: begin
        state_d = frnd_pkg::ST_A1;
      end
      frnd_pkg::ST_A1: begin
        state_d = frnd_pkg::ST_A2;
      end
      frnd_pkg::ST_A2: begin
        state_d = frnd_pkg::ST_FIN;
      end
      frnd_pkg::ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = frnd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = frnd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frnd_pkg::ST_IDLE;
      cnt_q       <= 9'd0;
      up_q        <= 8'd0;
      dn_q        <= 8'd0;
      tog_q       <= 1'b0;
      full_q      <= 1'b0;
      ring_q      <= 1'b0;
      rd_nb_q     <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= frnd_pkg::NeuronCountRst;
      reach_q     <= frnd_pkg::ReachRst;
      gain_q      <= frnd_pkg::GainRst;
      drive_q     <= frnd_pkg::DriveRst;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      up_q    <= up_d;
      dn_q    <= dn_d;
      tog_q   <= tog_d;
      full_q  <= full_d;
      ring_q  <= ring_d;
      rd_nb_q <= rd_nb_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          frnd_pkg::RegNeuronCount:    count_q <= cfg_wdata_i[8:0];
          frnd_pkg::RegNeighbourReach: reach_q <= cfg_wdata_i[6:0];
          frnd_pkg::RegCouplingGain:   gain_q  <= cfg_wdata_i[16:0];
          frnd_pkg::RegDriveCurrent:   drive_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // sixteen folded high parts times (2^32 - 1) / 15
  assign fold_hi = {1'b0, u_q[35:32]} + {4'd0, z_q[32]};
  assign cpl_s   = sneg_q ? -$signed({1'b0, pmag_q}) : $signed({1'b0, pmag_q});
  assign clip_a  = frnd_pkg::clip32(a_q);
  assign clip_r  = frnd_pkg::clip32(64'(rr_q));

  always_ff @(posedge clk_i) begin
    if (rd_nb_q) begin
      acc_q <= acc_q + 41'(x_rdata_s) - 41'(x_q);
    end
    case (state_q)
      frnd_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_q <= in_idx;
        end
      end
      frnd_pkg::ST_LD_OWN: begin
        x_q    <= x_own;
        w_q    <= in_store ? $signed(w_rdata) : 32'sd0;
        xmag_q <= x_own[31] ? 32'(-x_own) : x_own;
        xneg_q <= x_own[31];
        acc_q  <= 41'sd0;
      end
      frnd_pkg::ST_SQ: begin
        num_q <= frnd_pkg::RecovOffset - (37'(x_q) <<< 2) - 37'(x_q) - (37'(w_q) <<< 2);
      end
      frnd_pkg::ST_CH: begin
        sqlo_q <= mul_p[31:0];
        rneg_q <= num_q[36];
        u_q    <= num_q[36] ? 36'(~num_q + 37'sd15) : 36'(num_q);
      end
      frnd_pkg::ST_CL: begin
        cube_q <= mul_p[61:0];
        z_q    <= {29'd0, u_q[35:32]} + {1'b0, u_q[31:0]};
        sneg_q <= acc_q[40];
        sabs_q <= acc_q[40] ? 41'(-acc_q) : 41'(acc_q);
      end
      frnd_pkg::ST_GL: begin
        cube_q <= cube_q + {30'd0, mul_p[63:32]};
        z2_q   <= z_q[31:0] + {31'd0, z_q[32]};
        qb_q   <= fold_hi[4] ? frnd_pkg::FoldSixteen : {2'd0, {8{fold_hi[3:0]}}};
      end
      frnd_pkg::ST_GH: begin
        plo_q <= mul_p[48:0];
      end
      frnd_pkg::ST_RM: begin
        pmag_q <= {mul_p[25:0], 32'd0} + {9'd0, plo_q};
      end
      frnd_pkg::ST_RS: begin
        rq_q <= qb_q + {5'd0, mul_p[63:35]};
        c_q  <= (idx_q == 8'd0) ? 43'(drive_q) : cpl_s[58:16];
      end
      frnd_pkg::ST_A1: begin
        s_q      <= 45'(x_q) + 45'(w_q) + 45'(c_q);
        rr_q     <= rneg_q ? -$signed({1'b0, rq_q}) : $signed({1'b0, rq_q});
        cube_s_q <= xneg_q ? -$signed({1'b0, cube_q}) : $signed({1'b0, cube_q});
      end
      frnd_pkg::ST_A2: begin
        a_q <= 64'(s_q) + (64'(s_q) <<< 1) - 64'(cube_s_q);
      end
      frnd_pkg::ST_FIN: begin
        if (out_load) begin
          out_data_q <= {clip_r.value, clip_a.value, idx_q};
          out_sat_q  <= clip_a.sat || clip_r.sat;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

  // neighbour reads stay inside the ring
  a_nb_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == frnd_pkg::ST_NB |-> {1'b0, nb_addr} < ring_n)
    else $error("neighbour address outside ring");

  // no coupling sum without a neighbour walk
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frnd_pkg::ST_GL && !ring_q) |-> acc_q == 41'sd0)
    else $error("coupling sum not clear");

  // a result appears only from the final step of a query
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == frnd_pkg::ST_FIN))
    else $error("result without finished query");

endmodule
